/* sv/rbm_pkg.sv */
package rbm_pkg;

    localparam int LABEL_W   = 10;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 6'd10;
    localparam logic [SIZE_W-1:0] COLS_RESET = 6'd10;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 6'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // cell beat taken: capture coins and do the right-wall merge
        logic cell_down;   // decide the down wall; post the cell result, or hold it in the last row
        logic row_end;     // relabel the next row
        logic close_step;  // one closing union of the last row
        logic emit;        // post one held result of the last row
        logic restart;     // back to the top-left cell with fresh labels
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_col;
        logic bottom_row;
        logic close_done;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/rbm_ifs.sv */
interface rbm_cell_if;
    logic valid;
    logic ready;
    logic right_coin;
    logic down_coin;

    modport source (output valid, output right_coin, output down_coin, input ready);
    modport sink (input valid, input right_coin, input down_coin, output ready);
endinterface

interface rbm_wall_if;
    logic                       valid;
    logic                       ready;
    logic [rbm_pkg::ROW_W-1:0]  cell_row;
    logic [rbm_pkg::COL_W-1:0]  cell_col;
    logic                       right_wall;
    logic                       floor_wall;
    logic                       last_of_run;

    modport source (output valid, output cell_row, output cell_col, output right_wall,
                    output floor_wall, output last_of_run, input ready);
    modport sink (input valid, input cell_row, input cell_col, input right_wall,
                  input floor_wall, input last_of_run, output ready);
endinterface

interface rbm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rbm_pkg::CFG_IDX_W-1:0] index;
    logic [rbm_pkg::SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/row_by_row_maze_generator.sv */
// Row-by-row maze generator. Cells arrive on i_cell in raster order, one beat
// per cell, each beat carrying a right coin and a down coin. Walls leave on
// o_wall, one beat per reported cell, with its row, column and walls.
// i_cfg writes the row count (index 0) or column count (index 1); a write
// restarts generation at the top-left cell. It is always ready.
// Outside the last row a cell goes through IDLE, which accepts it and does the
// right-wall union across the label row, then DOWN, which counts open cells of
// its set and posts the result. The last column of a row adds a relabel state.
// Cells of the last row post nothing until the row's final cell; then the
// cols-1 closing unions run, one union per cycle through the shared compare
// row, and the held row leaves as cols beats, the last one marked.
// A result sits in an output register, so a stalled receiver only holds the
// block once a second result is ready to post. Reset sets both sizes to 10
// and clears labels, walls and counters at once; no clearing pass is needed.
module row_by_row_maze_generator #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rbm_cell_if.sink   i_cell,
    rbm_wall_if.source o_wall,
    rbm_cfg_if.sink    i_cfg
);

    rbm_pkg::t_dp_cmd cmd;
    rbm_pkg::t_dp_sts sts;

    // The user must write configuration only while the block is idle; the block itself does not enforce it.
    assign i_cfg.ready = 1'b1;

    rbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell.valid),
        .o_in_ready (i_cell.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rbm_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_right_coin  (i_cell.right_coin),
        .i_down_coin   (i_cell.down_coin),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_wall.valid),
        .i_out_ready   (o_wall.ready),
        .o_cell_row    (o_wall.cell_row),
        .o_cell_col    (o_wall.cell_col),
        .o_right_wall  (o_wall.right_wall),
        .o_floor_wall  (o_wall.floor_wall),
        .o_last_of_run (o_wall.last_of_run)
    );

endmodule

/* sv/rbm_ctrl.sv */
module rbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rbm_pkg::t_dp_sts  i_sts,
    output rbm_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOWN,
        ST_ROW_END,
        ST_CLOSE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DOWN;
                end
            end
            ST_DOWN: begin
                // The last row posts nothing yet, so it never waits on the output.
                if (i_sts.bottom_row || i_sts.out_free) begin
                    o_cmd.cell_down = 1'b1;
                    if (!i_sts.last_col) begin
                        n_state = ST_IDLE;
                    end else if (!i_sts.bottom_row) begin
                        n_state = ST_ROW_END;
                    end else begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_ROW_END: begin
                o_cmd.row_end = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_CLOSE: begin
                o_cmd.close_step = 1'b1;
                if (i_sts.close_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/rbm_dp.sv */
module rbm_dp #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbm_pkg::t_dp_cmd              i_cmd,
    output rbm_pkg::t_dp_sts              o_sts,
    input  logic                          i_right_coin,
    input  logic                          i_down_coin,
    input  logic                          i_cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbm_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rbm_pkg::ROW_W-1:0]     o_cell_row,
    output logic [rbm_pkg::COL_W-1:0]     o_cell_col,
    output logic                          o_right_wall,
    output logic                          o_floor_wall,
    output logic                          o_last_of_run
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW = rbm_pkg::LABEL_W;
    localparam int SW = rbm_pkg::SIZE_W;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] hi);
        logic [SW-1:0] res;
        if (v < rbm_pkg::SIZE_MIN) begin
            res = rbm_pkg::SIZE_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [SW-1:0] r_rows;
    logic [SW-1:0] r_cols;

    logic [LW-1:0] r_labels [MAX_COLS];
    logic [LW-1:0] n_labels [MAX_COLS];
    logic [MAX_COLS-1:0] r_dw;
    logic [MAX_COLS-1:0] n_dw;
    logic [MAX_COLS-1:0] r_lrrw;

    logic [rbm_pkg::ROW_W-1:0] r_row;
    logic [rbm_pkg::COL_W-1:0] r_col;
    logic [rbm_pkg::COL_W-1:0] r_k;
    logic [LW-1:0]             r_base;
    logic                      r_rw;
    logic                      r_dcoin;

    logic [SW-1:0]       nrows;
    logic [SW-1:0]       ncols;
    logic [MAX_COLS-1:0] active;
    logic [CW-1:0]       idx;
    logic [CW:0]         idx1_w;
    logic [CW-1:0]       idx1;
    logic [LW-1:0]       la;
    logic [LW-1:0]       lb;
    logic                merge_do;
    logic [MAX_COLS-1:0] open_m;
    logic                open_two;
    logic                dw_c_next;
    logic [LW-1:0]       n_base;
    logic                cfg_restart;
    logic                restart;
    logic                out_load;

    assign nrows = clamp_size(r_rows, SW'(MAX_ROWS));
    assign ncols = clamp_size(r_cols, SW'(MAX_COLS));

    assign o_sts.last_col   = ({1'b0, r_col} == ncols - 6'd1);
    assign o_sts.bottom_row = ({1'b0, r_row} == nrows - 6'd1);
    assign o_sts.close_done = ({1'b0, r_k} == ncols - 6'd2);
    assign o_sts.emit_last  = ({1'b0, r_k} == ncols - 6'd1);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

    assign cfg_restart = i_cfg_we &&
                         (i_cfg_index == rbm_pkg::REG_ROWS || i_cfg_index == rbm_pkg::REG_COLS);
    assign restart     = cfg_restart || i_cmd.restart;

    // The shared union port: the cell's own column, or the closing pointer.
    assign idx    = i_cmd.close_step ? r_k[CW-1:0] : r_col[CW-1:0];
    assign idx1_w = {1'b0, idx} + 1'b1;
    assign idx1   = (idx1_w < (CW+1)'(MAX_COLS)) ? idx1_w[CW-1:0] : '0;
    assign la     = r_labels[idx];
    assign lb     = r_labels[idx1];

    assign merge_do = (i_cmd.accept && !o_sts.last_col && !i_right_coin && la != lb) ||
                      i_cmd.close_step;

    // At least two open cells share the label of this column.
    always_comb begin
        for (int k = 0; k < MAX_COLS; k++) begin
            open_m[k] = active[k] && (r_labels[k] == la) && !r_dw[k];
        end
    end
    assign open_two  = |(open_m & (open_m - 1'b1));
    assign dw_c_next = r_dw[idx] || (r_dcoin && open_two);

    assign n_base = r_base + LW'(ncols);

    always_comb begin
        for (int k = 0; k < MAX_COLS; k++) begin
            active[k]   = (SW'(k) < ncols);
            n_labels[k] = r_labels[k];
            n_dw[k]     = r_dw[k];
            if (restart) begin
                n_labels[k] = LW'(k);
                n_dw[k]     = 1'b0;
            end else if (merge_do) begin
                if (active[k] && r_labels[k] == lb) begin
                    n_labels[k] = la;
                end
            end else if (i_cmd.cell_down) begin
                if (CW'(k) == idx) begin
                    n_dw[k] = dw_c_next;
                end
            end else if (i_cmd.row_end) begin
                if (active[k] && r_dw[k]) begin
                    n_labels[k] = n_base + LW'(k);
                end
                n_dw[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= rbm_pkg::ROWS_RESET;
            r_cols <= rbm_pkg::COLS_RESET;
            for (int k = 0; k < MAX_COLS; k++) begin
                r_labels[k] <= LW'(k);
            end
            r_dw   <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_k    <= '0;
            r_base <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == rbm_pkg::REG_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == rbm_pkg::REG_COLS) begin
                r_cols <= i_cfg_data;
            end
            r_labels <= n_labels;
            r_dw     <= n_dw;
            if (restart) begin
                r_row  <= '0;
                r_col  <= '0;
                r_k    <= '0;
                r_base <= '0;
            end else if (i_cmd.cell_down) begin
                if (!o_sts.last_col) begin
                    r_col <= r_col + 1'b1;
                end else begin
                    r_k <= '0;
                end
            end else if (i_cmd.row_end) begin
                r_row  <= r_row + 1'b1;
                r_col  <= '0;
                r_base <= n_base;
            end else if (i_cmd.close_step) begin
                r_k <= o_sts.close_done ? '0 : r_k + 1'b1;
            end else if (i_cmd.emit) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // The down coin and the right-wall decision of the cell at work.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rw    <= !o_sts.last_col && (i_right_coin || la == lb);
            r_dcoin <= i_down_coin;
        end
    end

    // Right walls of the last row; each entry is written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_down && o_sts.bottom_row) begin
            r_lrrw[idx] <= r_rw;
        end else if (i_cmd.close_step && la != lb) begin
            r_lrrw[idx] <= 1'b0;
        end
    end

    assign out_load = (i_cmd.cell_down && !o_sts.bottom_row) || i_cmd.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_cell_row <= r_row;
            if (i_cmd.emit) begin
                o_cell_col    <= r_k;
                o_right_wall  <= r_lrrw[r_k[CW-1:0]];
                o_floor_wall  <= 1'b1;
                o_last_of_run <= o_sts.emit_last;
            end else begin
                o_cell_col    <= r_col;
                o_right_wall  <= r_rw;
                o_floor_wall  <= dw_c_next;
                o_last_of_run <= 1'b1;
            end
        end
    end

endmodule

/* verif/rbm_wall_checker.sv */
module rbm_wall_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rbm_cell_if  cell_ch,
    rbm_wall_if  wall,
    rbm_cfg_if   cfg,
    output int   o_failures,
    output int   o_pending,
    output int   o_walls_checked
);

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int ROW_W    = rbm_pkg::ROW_W;
    localparam int COL_W    = rbm_pkg::COL_W;
    localparam int SIZE_W   = rbm_pkg::SIZE_W;
    localparam int LABEL_W  = rbm_pkg::LABEL_W;

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             right_wall;
        logic             floor_wall;
        logic             last_of_run;
    } t_wall_beat;

    // Wall beats still owed by the block, oldest first.
    t_wall_beat pending_walls[$];

    logic [SIZE_W-1:0]  rows_reg;
    logic [SIZE_W-1:0]  cols_reg;
    logic [LABEL_W-1:0] set_labels [MAX_COLS];
    logic               floor_walls [MAX_COLS];
    logic               held_right [MAX_COLS];
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    int                 failures = 0;
    int                 checked = 0;

    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < rbm_pkg::SIZE_MIN) return rbm_pkg::SIZE_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_maze();
        for (int i = 0; i < MAX_COLS; i++) begin
            set_labels[i]  = LABEL_W'(i);
            floor_walls[i] = 1'b0;
            held_right[i]  = 1'b0;
        end
        cur_row = '0;
        cur_col = '0;
    endtask

    task automatic merge_labels(input logic [LABEL_W-1:0] to_label,
                                input logic [LABEL_W-1:0] from_label, input int ncols);
        for (int i = 0; i < ncols; i++)
            if (set_labels[i] == from_label) set_labels[i] = to_label;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input t_wall_beat at_beat);
        if (got !== want)
            report_mismatch($sformatf("%s of cell (%0d,%0d): got %0d, expected %0d",
                                      name, at_beat.cell_row, at_beat.cell_col, got, want));
    endtask

    // Advances the maze by one cell and queues the wall beats it releases.
    task automatic predict_cell_walls(input logic rcoin, input logic dcoin);
        int               nrows;
        int               ncols;
        int               open_cells;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic             rw;
        logic             on_bottom_row;
        logic             on_last_col;
        t_wall_beat       beat;

        nrows = clamp_size(rows_reg, MAX_ROWS);
        ncols = clamp_size(cols_reg, MAX_COLS);
        if (cur_row >= nrows || cur_col >= ncols) restart_maze();
        r = cur_row;
        c = cur_col;
        on_bottom_row = (r == nrows - 1);
        on_last_col   = (c == ncols - 1);

        rw = 1'b0;
        if (!on_last_col) begin
            if (rcoin || set_labels[c] == set_labels[c + 1]) rw = 1'b1;
            else merge_labels(set_labels[c], set_labels[c + 1], ncols);
        end

        open_cells = 0;
        for (int k = 0; k < ncols; k++)
            if (set_labels[k] == set_labels[c] && !floor_walls[k]) open_cells++;
        if (dcoin && open_cells > 1) floor_walls[c] = 1'b1;

        if (!on_bottom_row) begin
            beat.cell_row    = r;
            beat.cell_col    = c;
            beat.right_wall  = rw;
            beat.floor_wall  = floor_walls[c];
            beat.last_of_run = 1'b1;
            pending_walls.push_back(beat);
            if (on_last_col) begin
                for (int k = 0; k < ncols; k++) begin
                    if (floor_walls[k])
                        set_labels[k] = LABEL_W'((int'(r) + 1) * ncols + k);
                    floor_walls[k] = 1'b0;
                end
                cur_row = r + 1'b1;
                cur_col = '0;
            end else begin
                cur_col = c + 1'b1;
            end
            return;
        end

        held_right[c] = rw;
        if (!on_last_col) begin
            cur_col = c + 1'b1;
            return;
        end

        // Closing pass of the bottom row: join all sets, opening walls between them.
        for (int k = 0; k + 1 < ncols; k++) begin
            if (set_labels[k] != set_labels[k + 1]) held_right[k] = 1'b0;
            merge_labels(set_labels[k], set_labels[k + 1], ncols);
        end
        for (int k = 0; k < ncols; k++) begin
            beat.cell_row    = r;
            beat.cell_col    = COL_W'(k);
            beat.right_wall  = held_right[k];
            beat.floor_wall  = 1'b1;
            beat.last_of_run = (k == ncols - 1);
            pending_walls.push_back(beat);
        end
        restart_maze();
    endtask

    always @(posedge i_clk) begin : watch
        t_wall_beat want;

        if (!i_rst_n) begin
            rows_reg = rbm_pkg::ROWS_RESET;
            cols_reg = rbm_pkg::COLS_RESET;
            restart_maze();
            pending_walls.delete();
        end else begin
            // The beat leaving now was posted before any cell taken at this edge.
            if (wall.valid && wall.ready) begin
                if (pending_walls.size() == 0) begin
                    report_mismatch($sformatf("unexpected wall beat for cell (%0d,%0d)",
                                              wall.cell_row, wall.cell_col));
                end else begin
                    want = pending_walls.pop_front();
                    check_field("cell_row", wall.cell_row, want.cell_row, want);
                    check_field("cell_col", wall.cell_col, want.cell_col, want);
                    check_field("right_wall", wall.right_wall, want.right_wall, want);
                    check_field("floor_wall", wall.floor_wall, want.floor_wall, want);
                    check_field("last_of_run", wall.last_of_run, want.last_of_run, want);
                    checked++;
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == rbm_pkg::REG_ROWS) begin
                    rows_reg = cfg.data;
                    restart_maze();
                end else if (cfg.index == rbm_pkg::REG_COLS) begin
                    cols_reg = cfg.data;
                    restart_maze();
                end
            end
            if (cell_ch.valid && cell_ch.ready)
                predict_cell_walls(cell_ch.right_coin, cell_ch.down_coin);
        end
        o_failures      = failures;
        o_pending       = pending_walls.size();
        o_walls_checked = checked;
    end

endmodule

/* verif/row_by_row_maze_generator_test.sv */
module row_by_row_maze_generator_test;

    localparam int SIZE_W    = rbm_pkg::SIZE_W;
    localparam int CFG_IDX_W = rbm_pkg::CFG_IDX_W;

    // Run control. The cycle limit sits far above the slowest legal run.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_GAP       = 11;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_CELLS  = 200;
    localparam int PHASE_CELLS   = 120;

    // Indexes that decode to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {SHAPE_TALL, SHAPE_WIDE, SHAPE_ANY, SHAPE_SMALL} t_maze_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbm_cell_if cell_ch ();
    rbm_wall_if wall_ch ();
    rbm_cfg_if  cfg_ch ();

    int failures;
    int pending_walls;
    int walls_checked;

    // Stimulus bookkeeping.
    int               cells_sent = 0;
    int               settings_used = 0;
    int               cycle_count = 0;
    bit               steady_source = 1'b0;
    bit               steady_sink = 1'b0;
    logic [SIZE_W-1:0] rows_set = rbm_pkg::ROWS_RESET;
    logic [SIZE_W-1:0] cols_set = rbm_pkg::COLS_RESET;

    // Receiver state: how many more cycles ready stays low.
    int  ready_hold = 0;
    bit  wall_taken;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    row_by_row_maze_generator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch),
        .o_wall  (wall_ch),
        .i_cfg   (cfg_ch)
    );

    rbm_wall_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .cell_ch         (cell_ch),
        .wall            (wall_ch),
        .cfg             (cfg_ch),
        .o_failures      (failures),
        .o_pending       (pending_walls),
        .o_walls_checked (walls_checked)
    );

    // Every input of the block is known from time zero.
    initial begin
        i_rst_n            = 1'b0;
        cell_ch.valid      = 1'b0;
        cell_ch.right_coin = 1'b0;
        cell_ch.down_coin  = 1'b0;
        wall_ch.ready      = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = rbm_pkg::REG_ROWS;
        cfg_ch.data        = '0;
    end

    // The wall receiver draws a fresh stall after every beat it takes. In a
    // steady phase it keeps ready high so the output runs back to back.
    always begin
        @(posedge i_clk);
        wall_taken = wall_ch.valid && wall_ch.ready;
        @(negedge i_clk);
        if (wall_taken) ready_hold = steady_sink ? 0 : $urandom_range(0, MAX_GAP);
        if (ready_hold > 0) begin
            wall_ch.ready <= 1'b0;
            ready_hold--;
        end else begin
            wall_ch.ready <= 1'b1;
        end
    end

    // Watchdog. A hang or a missing wall beat ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d wall beats outstanding",
                     cycle_count, pending_walls);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one cell beat. It is entered and left at a falling edge, so a
    // back-to-back cell only updates the coins and valid is never lowered
    // and raised within the same step.
    task automatic send_cell(input logic rcoin, input logic dcoin);
        int gap;

        gap = steady_source ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.right_coin <= rcoin;
        cell_ch.down_coin  <= dcoin;
        do @(posedge i_clk); while (!cell_ch.ready);
        @(negedge i_clk);
        cells_sent++;
    endtask

    // Stops sending and waits until every predicted wall beat has left.
    // Cells of the bottom row post nothing, so it then keeps waiting to let the
    // block finish a cell that owes no beat.
    task automatic drain_walls();
        cell_ch.valid <= 1'b0;
        while (pending_walls != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register writes happen only while the block is idle, after a drain.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        if (idx == rbm_pkg::REG_ROWS) rows_set = value;
        if (idx == rbm_pkg::REG_COLS) cols_set = value;
    endtask

    // Size the block really uses for a register value, for planning phases.
    function automatic int effective_size(input logic [SIZE_W-1:0] v);
        if (v < rbm_pkg::SIZE_MIN) return rbm_pkg::SIZE_MIN;
        if (v > 32) return 32;
        return v;
    endfunction

    // One random phase: pick a maze shape, program it, then feed cells whose
    // coins lean one way, the other or neither, so that both long merged runs and
    // heavily walled rows show up. Most phases finish at least one maze and
    // stop part way through the next one. The phase never sends more cells
    // than the budget it is given.
    task automatic run_random_phase(input t_maze_shape shape, input int budget);
        int                ncells;
        int                area;
        int                right_pct;
        int                down_pct;
        logic [SIZE_W-1:0] rows_val;
        logic [SIZE_W-1:0] cols_val;

        case (shape)
            SHAPE_TALL: begin
                case ($urandom_range(0, 2))
                    0: rows_val = 6'd32;
                    1: rows_val = 6'd33;
                    default: rows_val = 6'd63;
                endcase
                cols_val = SIZE_W'($urandom_range(2, 3));
            end
            SHAPE_WIDE: begin
                rows_val = SIZE_W'($urandom_range(2, 3));
                case ($urandom_range(0, 2))
                    0: cols_val = 6'd32;
                    1: cols_val = 6'd33;
                    default: cols_val = 6'd63;
                endcase
            end
            SHAPE_ANY: begin
                rows_val = SIZE_W'($urandom_range(0, 63));
                cols_val = SIZE_W'($urandom_range(0, 63));
            end
            default: begin
                rows_val = SIZE_W'($urandom_range(2, 6));
                cols_val = SIZE_W'($urandom_range(2, 6));
            end
        endcase

        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = ($urandom_range(0, 3) == 0);

        // Now and then the current maze simply carries on with no write.
        if (shape == SHAPE_SMALL && $urandom_range(0, 5) == 0) begin
            rows_val = rows_set;
            cols_val = cols_set;
        end else begin
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          SIZE_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 1)) begin
                write_reg(rbm_pkg::REG_ROWS, rows_val);
                write_reg(rbm_pkg::REG_COLS, cols_val);
            end else begin
                write_reg(rbm_pkg::REG_COLS, cols_val);
                write_reg(rbm_pkg::REG_ROWS, rows_val);
            end
            settings_used++;
        end

        area   = effective_size(rows_val) * effective_size(cols_val);
        ncells = $urandom_range(1, 2) * area + $urandom_range(0, area - 1);
        if (ncells > PHASE_CELLS) ncells = PHASE_CELLS;
        if (ncells > budget) ncells = budget;

        case ($urandom_range(0, 2))
            0: right_pct = 10;
            1: right_pct = 50;
            default: right_pct = 90;
        endcase
        case ($urandom_range(0, 2))
            0: down_pct = 10;
            1: down_pct = 50;
            default: down_pct = 90;
        endcase

        for (int i = 0; i < ncells; i++)
            send_cell($urandom_range(0, 99) < right_pct, $urandom_range(0, 99) < down_pct);
        drain_walls();
    endtask

    initial begin
        int          random_start;
        int          phase_no;
        t_maze_shape shape;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. First a few cells of the default 10 by 10 maze with
        // every coin pair, checking the sizes that reset leaves behind.
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b0);
        drain_walls();

        // Register values below the minimum are used as 2, giving the
        // smallest maze. Two whole mazes run through, so the bottom row
        // burst and the wrap to a new maze are both seen.
        write_reg(rbm_pkg::REG_ROWS, 6'd0);
        write_reg(rbm_pkg::REG_COLS, 6'd1);
        settings_used++;
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b1);
        send_cell(1'b1, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b1);
        drain_walls();

        // A 2 by 3 maze, interrupted mid-row by writes to indexes that hold
        // no register: the maze must carry on where it was.
        write_reg(rbm_pkg::REG_ROWS, 6'd2);
        write_reg(rbm_pkg::REG_COLS, 6'd3);
        settings_used++;
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b0);
        drain_walls();
        write_reg(REG_SPARE_A, 6'd63);
        write_reg(REG_SPARE_B, 6'd0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);
        drain_walls();

        // Random part. The first two phases force the tallest and the widest
        // mazes; after that small mazes dominate so that many complete.
        random_start = cells_sent;
        phase_no = 0;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            if (phase_no == 0) begin
                shape = SHAPE_TALL;
            end else if (phase_no == 1) begin
                shape = SHAPE_WIDE;
            end else begin
                case ($urandom_range(0, 9))
                    0: shape = SHAPE_TALL;
                    1: shape = SHAPE_WIDE;
                    2: shape = SHAPE_ANY;
                    default: shape = SHAPE_SMALL;
                endcase
            end
            run_random_phase(shape, RANDOM_CELLS - (cells_sent - random_start));
            phase_no++;
        end

        // Let any stray beat surface before the verdict.
        drain_walls();
        repeat (40) @(negedge i_clk);

        $display("Sent %0d cells (%0d directed) across %0d maze size settings.",
                 cells_sent, random_start, settings_used);
        $display("Checked %0d wall beats, including clamped sizes and full bottom rows.",
                 walls_checked);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
sv/rbm_pkg.sv
sv/rbm_ifs.sv
sv/rbm_ctrl.sv
sv/rbm_dp.sv
sv/row_by_row_maze_generator.sv
verif/rbm_wall_checker.sv
verif/row_by_row_maze_generator_test.sv
